### src/kmp_pkg.sv
// shared types, constants and codes for the kmp substring search block
package kmp_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int J_W         = LEN_W + 1;
  localparam int GUARD_LIMIT = MAX_PATTERN + 1;

  localparam logic signed [LEN_W-1:0] K_NONE = '1;
  localparam logic signed [J_W-1:0]   J_NONE = '1;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_PREPARE = 2'd1,
    REQ_TEXT    = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BCMP,
    ST_BWR,
    ST_SCMP,
    ST_SFIN
  } kmp_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pattern_index;
    logic [7:0] symbol;
  } kmp_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_start;
    logic [31:0] bytes_seen;
  } kmp_rsp_t;

  typedef struct packed {
    logic pat_wr;
    logic build_init;
    logic build_mode;
    logic build_step;
    logic build_fall;
    logic table_wr;
    logic search_init;
    logic search_adv;
    logic search_fall;
    logic finish;
  } kmp_cmd_t;

  typedef struct packed {
    logic build_more;
    logic build_hit;
    logic search_hit;
    logic found;
    logic out_block;
  } kmp_stat_t;

endpackage

### src/kmp_ctrl.sv
// controller state machine sequencing table build and text search
module kmp_ctrl import kmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  input  kmp_stat_t  stat,
  output logic       req_ready,
  output kmp_cmd_t   cmd
);

  kmp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          case (req_type)
            REQ_LOAD: begin
              cmd.pat_wr = 1'b1;
            end
            REQ_PREPARE: begin
              cmd.build_init = 1'b1;
              cmd.build_mode = 1'b1;
              state_next     = ST_BCMP;
            end
            REQ_TEXT: begin
              if (stat.found) begin
                state_next = ST_SFIN;
              end else begin
                cmd.search_init = 1'b1;
                state_next      = ST_SCMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BCMP: begin
        cmd.build_mode = 1'b1;
        if (!stat.build_more) begin
          state_next = ST_IDLE;
        end else if (stat.build_hit) begin
          cmd.build_step = 1'b1;
          state_next     = ST_BWR;
        end else begin
          cmd.build_fall = 1'b1;
        end
      end
      ST_BWR: begin
        cmd.build_mode = 1'b1;
        cmd.table_wr   = 1'b1;
        state_next     = ST_BCMP;
      end
      ST_SCMP: begin
        if (stat.search_hit) begin
          cmd.search_adv = 1'b1;
          state_next     = ST_SFIN;
        end else begin
          cmd.search_fall = 1'b1;
        end
      end
      ST_SFIN: begin
        if (!stat.out_block) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/kmp_datapath.sv
// datapath: pattern and failure memories, match pointers, counters, result register
module kmp_datapath import kmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  kmp_req_t   req,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data,
  input  kmp_cmd_t   cmd,
  input  logic       rsp_ready,
  output kmp_stat_t  stat,
  output logic       rsp_valid,
  output kmp_rsp_t   rsp
);

  logic [7:0]              pat_mem  [MAX_PATTERN];
  logic signed [LEN_W-1:0] fail_mem [MAX_PATTERN];

  logic [LEN_W-1:0]        len;
  logic signed [J_W-1:0]   j, j_next;
  logic signed [LEN_W-1:0] k, k_next;
  logic [LEN_W-1:0]        guard, guard_next;
  logic [7:0]              sym;
  logic [LEN_W-1:0]        match_index;
  logic [31:0]             text_counter;
  logic                    found_flag;
  logic [31:0]             first_match_start;

  logic [7:0]              pj_q, pk_q;
  logic signed [LEN_W-1:0] f_q;

  logic [IDX_W-1:0]        j_addr, k_addr, f_addr;
  logic [LEN_W-1:0]        j0;
  logic signed [LEN_W-1:0] fv;
  logic signed [LEN_W-1:0] tbl_val;
  logic signed [J_W-1:0]   len_j;
  logic [31:0]             tc_inc, fms_calc;
  logic                    hit_full;
  logic                    found_n;
  logic [31:0]             tc_n, fms_n;
  logic [LEN_W-1:0]        mi_n;

  // effective pattern length kept in range
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(1);
    end else if (cfg_we) begin
      if (cfg_data == '0) begin
        len <= LEN_W'(1);
      end else if ({1'b0, cfg_data} > (LEN_W + 1)'(MAX_PATTERN)) begin
        len <= LEN_W'(MAX_PATTERN);
      end else begin
        len <= LEN_W'(cfg_data);
      end
    end
  end

  assign j0     = (match_index < len) ? match_index : '0;
  assign len_j  = $signed({1'b0, len});
  assign j_addr = j_next[IDX_W-1:0];
  assign k_addr = k_next[IDX_W-1:0];
  assign f_addr = cmd.build_mode ? k_addr : j_addr;

  always_comb begin
    j_next     = j;
    k_next     = k;
    guard_next = guard;
    fv         = (j == '0) ? K_NONE : f_q;
    if (fv < K_NONE) begin
      fv = K_NONE;
    end
    if (cmd.build_init) begin
      j_next = '0;
      k_next = K_NONE;
    end
    if (cmd.search_init) begin
      j_next     = $signed({1'b0, j0});
      guard_next = '0;
    end
    if (cmd.build_step) begin
      j_next = j + J_W'(1);
      k_next = k + LEN_W'(1);
    end
    if (cmd.build_fall) begin
      k_next = (k == '0) ? K_NONE : f_q;
    end
    if (cmd.search_adv) begin
      j_next = j + J_W'(1);
    end
    if (cmd.search_fall) begin
      guard_next = guard + LEN_W'(1);
      j_next     = (guard_next > LEN_W'(GUARD_LIMIT)) ? J_NONE : J_W'(fv);
    end
  end

  assign tbl_val = (pj_q != pk_q) ? k : ((k == '0) ? K_NONE : f_q);

  // memories with registered reads at the next pointer values
  always_ff @(posedge clk) begin
    if (cmd.pat_wr && ({1'b0, req.pattern_index} < (IDX_W + 1)'(MAX_PATTERN))) begin
      pat_mem[req.pattern_index[IDX_W-1:0]] <= req.symbol;
    end
    pj_q <= pat_mem[j_addr];
    pk_q <= pat_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.table_wr) begin
      fail_mem[j[IDX_W-1:0]] <= tbl_val;
    end
    f_q <= fail_mem[f_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j     <= '0;
      k     <= K_NONE;
      guard <= '0;
    end else begin
      j     <= j_next;
      k     <= k_next;
      guard <= guard_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      sym <= req.symbol;
    end
  end

  // result of one text byte
  assign tc_inc   = (text_counter == '1) ? text_counter : text_counter + 32'd1;
  assign hit_full = (j >= len_j);
  assign fms_calc = (tc_inc >= 32'(len)) ? tc_inc - 32'(len) : '0;

  always_comb begin
    found_n = found_flag;
    tc_n    = text_counter;
    fms_n   = first_match_start;
    mi_n    = match_index;
    if (!found_flag) begin
      tc_n = tc_inc;
      if (hit_full) begin
        found_n = 1'b1;
        fms_n   = fms_calc;
        mi_n    = '0;
      end else begin
        mi_n = j[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_index       <= '0;
      text_counter      <= '0;
      found_flag        <= 1'b0;
      first_match_start <= '0;
    end else if (cmd.build_init) begin
      match_index       <= '0;
      text_counter      <= '0;
      found_flag        <= 1'b0;
      first_match_start <= '0;
    end else if (cmd.finish) begin
      match_index       <= mi_n;
      text_counter      <= tc_n;
      found_flag        <= found_n;
      first_match_start <= fms_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.found       <= found_n;
      rsp.match_start <= found_n ? fms_n : '0;
      rsp.bytes_seen  <= tc_n;
    end
  end

  assign stat.build_more = (j < $signed({1'b0, len - LEN_W'(1)}));
  assign stat.build_hit  = (k == K_NONE) || (pj_q == pk_q);
  assign stat.search_hit = (j == J_NONE) || (sym == pj_q);
  assign stat.found      = found_flag;
  assign stat.out_block  = rsp_valid && !rsp_ready;

`ifndef SYNTH
  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    found_flag && !cmd.build_init |=> found_flag)
    else $error("found flag dropped without prepare");

  a_found_idx_zero: assert property (@(posedge clk) disable iff (rst)
    found_flag |-> match_index == '0)
    else $error("match index not cleared after match");

  a_table_order: assert property (@(posedge clk) disable iff (rst)
    cmd.table_wr |-> (k >= 0) && (k < j))
    else $error("failure entry written out of order");

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rsp_valid && !rsp_ready))
    else $error("result overwritten before transaction");
`endif

endmodule

### src/kmp_substring_search.sv
// top level of the kmp substring search block
//
//   channel | signals                        | carries
//   --------+--------------------------------+-----------------------------------
//   req     | req_valid, req_ready, req      | load, prepare or text byte
//   rsp     | rsp_valid, rsp_ready, rsp      | found, match_start, bytes_seen
//   cfg     | cfg_valid, cfg_ready, cfg_data | pattern_length
//
// load: taken while idle. text byte: compare state, repeated per failure-chain step, then
// finish (only finish once found); compares use registered pattern and failure reads.
// prepare: compare state per chain step, compare and write states per table entry.
// a result waits in the rsp register; a text transaction stalls only if it is still held.
// synchronous reset; memories hold no reset value and need no clearing pass.
module kmp_substring_search import kmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  kmp_req_t   req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output kmp_rsp_t   rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);

  kmp_cmd_t  cmd;
  kmp_stat_t stat;

  assign cfg_ready = 1'b1;

  kmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .stat      (stat),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  kmp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

### verif/kmp_search_checker.sv
`timescale 1ns / 1ps
// checker for kmp_substring_search: predicts each result transaction and compares it
module kmp_search_checker import kmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  kmp_req_t   req,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  kmp_rsp_t   rsp,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [8:0] cfg_data,
  output int         pending,
  output int         failures
);

  localparam int NO_FALLBACK = -1;

  logic [7:0]  pat_mem  [MAX_PATTERN];
  int          fall_mem [MAX_PATTERN];
  logic [8:0]  len_reg;
  int          cursor;
  logic [31:0] seen_cnt;
  logic        hit;
  logic [31:0] hit_start;
  kmp_rsp_t    expected_q [$];
  kmp_rsp_t    want;
  int          n;
  int          j;
  int          k;
  int          hops;
  logic        stepped;

  function automatic int active_len(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > MAX_PATTERN) return MAX_PATTERN;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    failures++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fall_mem[0] = NO_FALLBACK;
      len_reg     = 9'd1;
      cursor      = 0;
      seen_cnt    = '0;
      hit         = 1'b0;
      hit_start   = '0;
      expected_q.delete();
      pending     = 0;
      failures    = 0;
    end else begin
      if (cfg_valid && cfg_ready) len_reg = cfg_data;

      if (req_valid && req_ready) begin
        case (req.req_type)
          REQ_LOAD: pat_mem[req.pattern_index] = req.symbol;
          REQ_PREPARE: begin
            // optimized failure table: equal next symbol inherits the fallback entry
            n = active_len(len_reg);
            k = NO_FALLBACK;
            j = 0;
            fall_mem[0] = NO_FALLBACK;
            while (j < n - 1) begin
              if (k == NO_FALLBACK || pat_mem[j] == pat_mem[k]) begin
                j++;
                k++;
                fall_mem[j] = (pat_mem[j] != pat_mem[k]) ? k : fall_mem[k];
              end else begin
                k = fall_mem[k];
              end
            end
            cursor    = 0;
            seen_cnt  = '0;
            hit       = 1'b0;
            hit_start = '0;
          end
          REQ_TEXT: begin
            if (!hit) begin
              n = active_len(len_reg);
              j = (cursor < n) ? cursor : 0;
              hops = 0;
              stepped = 1'b0;
              while (!stepped) begin
                if (j == NO_FALLBACK || req.symbol == pat_mem[j]) begin
                  j++;
                  stepped = 1'b1;
                end else begin
                  j = fall_mem[j];
                  if (j < NO_FALLBACK || j >= MAX_PATTERN) j = NO_FALLBACK;
                  hops++;
                  if (hops > MAX_PATTERN + 1) j = NO_FALLBACK;
                end
              end
              if (seen_cnt != '1) seen_cnt++;
              if (j >= n) begin
                hit       = 1'b1;
                hit_start = (seen_cnt >= 32'(n)) ? seen_cnt - 32'(n) : '0;
                cursor    = 0;
              end else begin
                cursor = j;
              end
            end
            want.found       = hit;
            want.match_start = hit ? hit_start : '0;
            want.bytes_seen  = seen_cnt;
            expected_q.push_back(want);
          end
          default: ;
        endcase
      end

      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected: found %0b start %0d seen %0d",
                                    rsp.found, rsp.match_start, rsp.bytes_seen));
        end else begin
          want = expected_q.pop_front();
          if (rsp.found !== want.found)
            report_mismatch($sformatf("found %0b, want %0b", rsp.found, want.found));
          if (rsp.match_start !== want.match_start)
            report_mismatch($sformatf("match_start %0d, want %0d",
                                      rsp.match_start, want.match_start));
          if (rsp.bytes_seen !== want.bytes_seen)
            report_mismatch($sformatf("bytes_seen %0d, want %0d",
                                      rsp.bytes_seen, want.bytes_seen));
        end
      end

      pending = expected_q.size();
    end
  end

endmodule

### verif/kmp_substring_search_tb.sv
`timescale 1ns / 1ps
// testbench top for kmp_substring_search: stimulus, watchdog and verdict
module kmp_substring_search_tb;
  import kmp_pkg::*;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam int         ITEM_TARGET    = 1250;
  localparam int         HOLDOFF        = 1100;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         CALM_FROM      = 450;
  localparam int         CALM_TO        = 650;

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  kmp_req_t   req;
  logic       rsp_valid;
  logic       rsp_ready;
  kmp_rsp_t   rsp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [8:0] cfg_data;
  int         pending;
  int         failures;

  int         items;
  bit         calm;
  bit         big;
  int         cur_len;
  int         stall_cycles;
  int         alpha_n;
  logic [7:0] alpha [3];
  logic [7:0] store_img [MAX_PATTERN];
  bit         loaded [MAX_PATTERN];
  bit         built [MAX_PATTERN];

  always #1 clk = ~clk;

  kmp_substring_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  kmp_search_checker search_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 19);
  endfunction

  function automatic logic [7:0] pick();
    if (alpha_n == 0) return 8'($urandom_range(255));
    return alpha[$urandom_range(alpha_n - 1, 0)];
  endfunction

  function automatic bit has_all(input int n, input bit need_built);
    for (int i = 0; i < n; i++)
      if (!loaded[i] || (need_built && !built[i])) return 1'b0;
    return 1'b1;
  endfunction

  always @(negedge clk) rsp_ready <= !idle_now();

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_req(input kmp_req_t item);
    @(negedge clk);
    if (idle_now()) begin
      req_valid <= 1'b0;
      @(negedge clk);
      while (idle_now()) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (item.req_type != REQ_UNUSED) items++;
    calm = (items >= CALM_FROM && items < CALM_TO);
  endtask

  task automatic load_byte(input int idx, input logic [7:0] s);
    kmp_req_t r;
    r.req_type      = REQ_LOAD;
    r.pattern_index = 8'(idx);
    r.symbol        = s;
    push_req(r);
    store_img[idx] = s;
    loaded[idx]    = 1'b1;
  endtask

  task automatic prepare_search();
    kmp_req_t r;
    r.req_type      = REQ_PREPARE;
    r.pattern_index = 8'($urandom_range(255));
    r.symbol        = 8'($urandom_range(255));
    push_req(r);
    for (int i = 0; i < cur_len; i++) built[i] = 1'b1;
  endtask

  task automatic send_text(input logic [7:0] s);
    kmp_req_t r;
    r.req_type      = REQ_TEXT;
    r.pattern_index = 8'($urandom_range(255));
    r.symbol        = s;
    push_req(r);
  endtask

  task automatic send_noise();
    kmp_req_t r;
    r.req_type      = REQ_UNUSED;
    r.pattern_index = 8'($urandom_range(255));
    r.symbol        = 8'($urandom_range(255));
    push_req(r);
  endtask

  // text byte, now and then preceded by a restart or a stray transaction
  task automatic stream_byte(input logic [7:0] s);
    if (!big) begin
      if ($urandom_range(39) == 0) prepare_search();
      if ($urandom_range(39) == 0) send_noise();
      if ($urandom_range(59) == 0) load_byte($urandom_range(255), 8'($urandom_range(255)));
    end
    send_text(s);
  endtask

  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (HOLDOFF) @(negedge clk);
  endtask

  task automatic set_length(input logic [8:0] v);
    settle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_len = (v == 0) ? 1 : (v > MAX_PATTERN) ? MAX_PATTERN : int'(v);
  endtask

  initial begin
    int         ph;
    int         n_len;
    int         pre_n;
    int         tail_n;
    int         txt_n;
    int         bad_at;
    logic [8:0] len_val;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    items     = 0;
    calm      = 1'b0;
    big       = 1'b0;
    cur_len   = 1;
    alpha_n   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // length 1 from reset, text before any prepare matches at once
    load_byte(0, 8'hFF);
    load_byte(255, 8'h00);
    load_byte(128, 8'h5A);
    send_text(8'hFF);
    send_text(8'h00);
    send_noise();
    prepare_search();
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'hFF);

    // zero length acts as one
    set_length(9'd0);
    prepare_search();
    send_text(8'hFF);

    // repeated symbols exercise inherited table entries
    set_length(9'd4);
    load_byte(0, 8'h61);
    load_byte(1, 8'h61);
    load_byte(2, 8'h61);
    load_byte(3, 8'h62);
    prepare_search();
    send_text(8'h61);
    send_text(8'h61);
    send_text(8'h61);

    // shorter length with the partial match beyond it restarts the match
    set_length(9'd2);
    send_text(8'h61);
    send_text(8'h61);

    ph = 0;
    while (items < ITEM_TARGET) begin
      big = (ph == 2 || ph == 9);
      if (big) n_len = MAX_PATTERN;
      else if ($urandom_range(9) == 0) n_len = $urandom_range(40, 13);
      else n_len = $urandom_range(8, 1);

      if (n_len == MAX_PATTERN)
        len_val = $urandom_range(1) ? 9'(MAX_PATTERN) : 9'($urandom_range(511, 257));
      else if (n_len == 1 && $urandom_range(1) == 1)
        len_val = 9'd0;
      else
        len_val = 9'(n_len);
      set_length(len_val);

      alpha_n = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
      for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom);

      if (!(has_all(n_len, 1'b0) && (big || $urandom_range(4) == 0))) begin
        for (int i = 0; i < n_len; i++) begin
          if ($urandom_range(19) == 0) send_noise();
          load_byte(i, pick());
        end
      end

      // sometimes search on with the table built earlier
      if (!(has_all(n_len, 1'b1) && $urandom_range(5) == 0)) prepare_search();

      if (ph != 9 && $urandom_range(3) != 0) begin
        pre_n  = $urandom_range((n_len < 6) ? 2 * n_len : 12, 0);
        bad_at = ($urandom_range(2) == 0) ? $urandom_range(n_len - 1, 0) : -1;
        tail_n = $urandom_range(3, 0);
        for (int i = 0; i < pre_n; i++) stream_byte(pick());
        for (int i = 0; i < n_len; i++) stream_byte((i == bad_at) ? pick() : store_img[i]);
        for (int i = 0; i < tail_n; i++) stream_byte(pick());
      end else begin
        txt_n = $urandom_range(big ? 40 : 3 * n_len + 4, 1);
        for (int i = 0; i < txt_n; i++) stream_byte(pick());
      end
      ph++;
    end

    settle();
    if (failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
